FILE: hdl/rau_pkg.sv
`default_nettype none
package rau_pkg;

  localparam int OPERAND_BITS = 16;
  localparam int PROD_BITS    = 2 * OPERAND_BITS;
  localparam int MAG_BITS     = PROD_BITS + 1;
  localparam int CNT_BITS     = $clog2(MAG_BITS + 1);
  localparam int RES_BITS     = 32;
  localparam int IN_BITS      = ((4 * OPERAND_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = 2 * RES_BITS;
  localparam int QDEPTH       = 2;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  // Raw fraction in sign and magnitude, handed from front to back.
  typedef struct packed {
    logic                n_neg;
    logic [MAG_BITS-1:0] n_mag;
    logic                d_neg;
    logic [MAG_BITS-1:0] d_mag;
  } raw_frac_t;

endpackage
`default_nettype wire

FILE: hdl/rau_front.sv
`default_nettype none
module rau_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_kind,
  input  wire logic [4*rau_pkg::OPERAND_BITS-1:0] in_ops,
  output logic                           q_valid,
  input  wire logic                      q_ready,
  output rau_pkg::raw_frac_t             q_data
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL1 = 4'b0010,
    F_MUL2 = 4'b0100,
    F_SUM  = 4'b1000
  } fstate_t;

  fstate_t state;
  logic [1:0] kind;
  logic [OPERAND_BITS-1:0] an, ad, bn, bd;
  logic                    p1_neg, p2_neg;
  logic [PROD_BITS-1:0]    p1_mag, p2_mag;
  logic                    d_neg;
  logic [PROD_BITS-1:0]    d_mag;
  logic                    mx_neg, my_neg;
  logic [OPERAND_BITS-1:0] mx, my;
  logic [OPERAND_BITS-1:0] mx_mag, my_mag;
  logic [PROD_BITS-1:0]    mprod;
  logic                    t_neg;
  logic                    s_neg;
  logic [MAG_BITS-1:0]     s_mag;
  logic                    push;

  // Two-entry queue to the back part.
  raw_frac_t qmem [QDEPTH];
  logic [0:0] wptr, rptr;
  logic [1:0] count;

  function automatic logic [OPERAND_BITS-1:0] mag_of(input logic [OPERAND_BITS-1:0] v);
    mag_of = v[OPERAND_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  // Shared multiplier: the first numerator product in F_MUL1, then the denominator product.
  always_comb begin
    if (state == F_MUL1) begin
      mx = an;
      my = (kind == KIND_MUL) ? bn : bd;
    end else begin
      mx = ad;
      my = (kind == KIND_DIV) ? bn : bd;
    end
    mx_neg = mx[OPERAND_BITS-1];
    my_neg = my[OPERAND_BITS-1];
    mx_mag = mag_of(mx);
    my_mag = mag_of(my);
    mprod  = PROD_BITS'(mx_mag) * PROD_BITS'(my_mag);
  end

  // Signed add or subtract of the two cross products.
  always_comb begin
    t_neg = p2_neg ^ (kind == KIND_SUB);
    if ((p1_neg == t_neg) || (p2_mag == '0)) begin
      s_mag = {1'b0, p1_mag} + {1'b0, p2_mag};
      s_neg = (p2_mag == '0) ? p1_neg : p1_neg;
    end else if (p1_mag >= p2_mag) begin
      s_mag = {1'b0, p1_mag - p2_mag};
      s_neg = p1_neg;
    end else begin
      s_mag = {1'b0, p2_mag - p1_mag};
      s_neg = t_neg;
    end
    if (s_mag == '0) s_neg = 1'b0;
  end

  assign in_ready = (state == F_IDLE);
  assign push     = (state == F_SUM) && (count != 2'(QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: if (in_valid) state <= F_MUL1;
        F_MUL1: state <= F_MUL2;
        F_MUL2: state <= F_SUM;
        F_SUM:  if (push) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid) begin
      kind <= in_kind;
      an   <= in_ops[OPERAND_BITS-1:0];
      ad   <= in_ops[2*OPERAND_BITS-1:OPERAND_BITS];
      bn   <= in_ops[3*OPERAND_BITS-1:2*OPERAND_BITS];
      bd   <= in_ops[4*OPERAND_BITS-1:3*OPERAND_BITS];
    end
    if (state == F_MUL1) begin
      p1_mag <= mprod;
      p1_neg <= (mprod != '0) && (mx_neg != my_neg);
    end
    if (state == F_MUL2) begin
      if (kind == KIND_MUL || kind == KIND_DIV) begin
        d_mag  <= mprod;
        d_neg  <= (mprod != '0) && (mx_neg != my_neg);
        p2_mag <= '0;
        p2_neg <= 1'b0;
      end else begin
        // Add and subtract still need the second cross product bn*ad.
        p2_mag <= PROD_BITS'(mag_of(bn)) * PROD_BITS'(mag_of(ad));
        p2_neg <= (bn[OPERAND_BITS-1] != ad[OPERAND_BITS-1]);
        d_mag  <= mprod;
        d_neg  <= (mprod != '0) && (mx_neg != my_neg);
      end
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (q_valid && q_ready) rptr <= rptr + 1'b1;
      count <= count + 2'(push) - 2'(q_valid && q_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wptr] <= '{n_neg: s_neg, n_mag: s_mag,
                      d_neg: d_neg, d_mag: {1'b0, d_mag}};
    end
  end

  assign q_valid = (count != '0);
  assign q_data  = qmem[rptr];
endmodule
`default_nettype wire

FILE: hdl/rau_back.sv
`default_nettype none
module rau_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  output logic                      q_ready,
  input  wire rau_pkg::raw_frac_t   q_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [rau_pkg::RES_BITS-1:0] out_num,
  output logic [rau_pkg::RES_BITS-1:0] out_den,
  output logic                      out_dz
);
  import rau_pkg::*;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_GCD  = 6'b000010,
    B_MOD  = 6'b000100,
    B_DIVN = 6'b001000,
    B_DIVD = 6'b010000,
    B_OUT  = 6'b100000
  } bstate_t;

  bstate_t state;
  raw_frac_t cur;
  logic [MAG_BITS-1:0] p, q, g;
  // Restoring divider shared by the gcd remainders and the final quotients.
  logic [MAG_BITS-1:0] dv_rem, dv_quo, dv_div;
  logic [CNT_BITS-1:0] cnt;
  logic [MAG_BITS:0]   trial;
  logic [MAG_BITS-1:0] quo_s;

  assign trial   = {dv_rem, dv_quo[MAG_BITS-1]} - {1'b0, dv_div};
  assign q_ready = (state == B_IDLE);

  always_comb begin
    quo_s = dv_quo << 1;
    if (!trial[MAG_BITS]) quo_s[0] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE: if (q_valid) begin
          cur <= q_data;
          p   <= q_data.n_mag;
          q   <= q_data.d_mag;
          if (q_data.d_mag == '0) begin
            out_num   <= '0;
            out_den   <= '0;
            out_dz    <= 1'b1;
            out_valid <= 1'b1;
            state     <= B_OUT;
          end else begin
            state <= B_GCD;
          end
        end
        B_GCD: begin
          if (q == '0) begin
            g      <= p;
            dv_rem <= '0;
            dv_quo <= cur.n_mag;
            dv_div <= p;
            cnt    <= '0;
            state  <= B_DIVN;
          end else begin
            dv_rem <= '0;
            dv_quo <= p;
            dv_div <= q;
            cnt    <= '0;
            state  <= B_MOD;
          end
        end
        B_MOD: begin
          dv_rem <= trial[MAG_BITS] ? {dv_rem[MAG_BITS-2:0], dv_quo[MAG_BITS-1]}
                                    : trial[MAG_BITS-1:0];
          dv_quo <= quo_s;
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_BITS'(MAG_BITS - 1)) begin
            p     <= q;
            q     <= trial[MAG_BITS] ? {dv_rem[MAG_BITS-2:0], dv_quo[MAG_BITS-1]}
                                     : trial[MAG_BITS-1:0];
            state <= B_GCD;
          end
        end
        B_DIVN: begin
          dv_rem <= trial[MAG_BITS] ? {dv_rem[MAG_BITS-2:0], dv_quo[MAG_BITS-1]}
                                    : trial[MAG_BITS-1:0];
          dv_quo <= quo_s;
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_BITS'(MAG_BITS - 1)) begin
            out_num <= cur.n_neg ? RES_BITS'(~quo_s + 1'b1) : RES_BITS'(quo_s);
            dv_rem  <= '0;
            dv_quo  <= cur.d_mag;
            dv_div  <= g;
            cnt     <= '0;
            state   <= B_DIVD;
          end
        end
        B_DIVD: begin
          dv_rem <= trial[MAG_BITS] ? {dv_rem[MAG_BITS-2:0], dv_quo[MAG_BITS-1]}
                                    : trial[MAG_BITS-1:0];
          dv_quo <= quo_s;
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_BITS'(MAG_BITS - 1)) begin
            out_den   <= cur.d_neg ? RES_BITS'(~quo_s + 1'b1) : RES_BITS'(quo_s);
            out_dz    <= 1'b0;
            out_valid <= 1'b1;
            state     <= B_OUT;
          end
        end
        B_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state     <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hdl/rational_arithmetic_unit.sv
`default_nettype none
// Rational arithmetic unit: adds, subtracts, multiplies or divides two
// signed fractions and reduces the result by the gcd of its magnitudes.
// Input channel s_axis_*: one beat carries the operation in tuser and the
// four operands in tdata. Output channel m_axis_*: one beat per input
// carries the reduced numerator and denominator in tdata and the
// zero-denominator flag in tuser.
// A front part forms the cross products with two multipliers and pushes
// them into a two-entry queue. A back part runs Euclid's loop on a
// bit-serial restoring divider, then two exact divisions by the gcd, of
// the numerator and of the denominator. Throughput is set by the back part,
// which takes one item at a time. A zero denominator skips the divider and
// yields 0/0.
// Reset (rst, synchronous) empties the queue and returns both parts to idle.
// When the receiver stalls, the result is held on m_axis_tdata; the queue fills
// and the front part then holds one more item before it stops accepting.
module rational_arithmetic_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // a_num, a_den, b_num, b_den from bit 0 up
  input  wire logic [rau_pkg::IN_BITS-1:0] s_axis_tdata,
  // kind
  input  wire logic [1:0]                s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // res_num, res_den from bit 0 up
  output logic [rau_pkg::OUT_BITS-1:0]   m_axis_tdata,
  // div_zero
  output logic                           m_axis_tuser
);
  import rau_pkg::*;

  logic      q_valid, q_ready;
  raw_frac_t q_data;
  logic [RES_BITS-1:0] num, den;

  rau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_kind  (s_axis_tuser),
    .in_ops   (s_axis_tdata[4*OPERAND_BITS-1:0]),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  rau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_num   (num),
    .out_den   (den),
    .out_dz    (m_axis_tuser)
  );

  assign m_axis_tdata = {den, num};
endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import rau_pkg::*;

  localparam int N_RANDOM   = 1800;
  localparam int WATCH_MAX  = 20000;
  localparam int DRAIN_WAIT = 1200;

  typedef struct {
    logic [31:0] num;
    logic [31:0] den;
    logic        dz;
  } fraction_result_t;

  typedef struct {
    kind_t       op;
    logic [15:0] an, ad, bn, bd;
    logic        known;
    logic [31:0] num, den;
    logic        dz;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_BITS-1:0]  s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_BITS-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  fraction_result_t pending_fractions[$];
  int  mismatches;
  int  idle_cycles;
  bit  sending_done;
  bit  quiet_phase;
  bit  hold_long;
  stim_row_t rows[$];

  rational_arithmetic_unit u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Exact rational result of one operation, reduced by the gcd of magnitudes.
  function automatic fraction_result_t reduce_fraction(kind_t op, logic [15:0] an,
      logic [15:0] ad, logic [15:0] bn, logic [15:0] bd);
    longint n, d, p, q, t;
    fraction_result_t r;
    case (op)
      KIND_ADD: begin
        n = longint'($signed(an)) * $signed(bd) + longint'($signed(bn)) * $signed(ad);
        d = longint'($signed(ad)) * $signed(bd);
      end
      KIND_SUB: begin
        n = longint'($signed(an)) * $signed(bd) - longint'($signed(bn)) * $signed(ad);
        d = longint'($signed(ad)) * $signed(bd);
      end
      KIND_MUL: begin
        n = longint'($signed(an)) * $signed(bn);
        d = longint'($signed(ad)) * $signed(bd);
      end
      default: begin
        n = longint'($signed(an)) * $signed(bd);
        d = longint'($signed(ad)) * $signed(bn);
      end
    endcase
    if (d == 0) begin
      r.num = '0;
      r.den = '0;
      r.dz  = 1'b1;
      return r;
    end
    p = (n < 0) ? -n : n;
    q = (d < 0) ? -d : d;
    while (q != 0) begin
      t = p % q;
      p = q;
      q = t;
    end
    r.num = 32'(n / p);
    r.den = 32'(d / p);
    r.dz  = 1'b0;
    return r;
  endfunction

  function automatic logic [15:0] random_operand();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'(int'($urandom_range(0, 20)) - 10);
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Sends one beat and records its expected result.
  task automatic send_fraction_pair(stim_row_t row);
    fraction_result_t e;
    e = reduce_fraction(row.op, row.an, row.ad, row.bn, row.bd);
    if (row.known) begin
      e.num = row.num;
      e.den = row.den;
      e.dz  = row.dz;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row.bd, row.bn, row.ad, row.an};
    s_axis_tuser  <= row.op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_fractions.push_back(e);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  function automatic stim_row_t mk(kind_t op, logic [15:0] an, logic [15:0] ad,
      logic [15:0] bn, logic [15:0] bd, logic known = 1'b0,
      logic [31:0] num = '0, logic [31:0] den = '0, logic dz = 1'b0);
    stim_row_t r;
    r.op = op; r.an = an; r.ad = ad; r.bn = bn; r.bd = bd;
    r.known = known; r.num = num; r.den = den; r.dz = dz;
    return r;
  endfunction

  // Stimulus: directed table, then random beats.
  initial begin
    stim_row_t r;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_ADD;
    sending_done  = 1'b0;
    quiet_phase   = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Zero denominators, zero numerators, sign keeping and operand extremes.
    rows.push_back(mk(KIND_ADD, 16'd1, 16'd0, 16'd1, 16'd2, 1'b1, 32'd0, 32'd0, 1'b1));
    rows.push_back(mk(KIND_MUL, 16'd0, 16'd0, 16'd0, 16'd5, 1'b1, 32'd0, 32'd0, 1'b1));
    rows.push_back(mk(KIND_DIV, 16'd3, 16'd4, 16'd0, 16'd5, 1'b1, 32'd0, 32'd0, 1'b1));
    rows.push_back(mk(KIND_MUL, 16'd0, 16'd3, 16'd7, 16'd5, 1'b1, 32'd0, 32'd1, 1'b0));
    rows.push_back(mk(KIND_MUL, 16'd0, -16'sd3, 16'd7, 16'd5, 1'b1, 32'd0, -32'sd1,
                      1'b0));
    rows.push_back(mk(KIND_MUL, -16'sd1, -16'sd2, 16'd1, 16'd1, 1'b1, -32'sd1, -32'sd2,
                      1'b0));
    rows.push_back(mk(KIND_SUB, 16'd1, 16'd2, 16'd1, 16'd2, 1'b1, 32'd0, 32'd1, 1'b0));
    rows.push_back(mk(KIND_ADD, 16'd1, 16'd2, 16'd1, 16'd2));
    rows.push_back(mk(KIND_SUB, 16'd1, 16'd3, 16'd1, 16'd2));
    rows.push_back(mk(KIND_DIV, 16'd2, 16'd3, 16'd4, 16'd9));
    rows.push_back(mk(KIND_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 32'd1,
                      32'd1, 1'b0));
    rows.push_back(mk(KIND_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1));
    rows.push_back(mk(KIND_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
    rows.push_back(mk(KIND_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000));
    rows.push_back(mk(KIND_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff));
    rows.push_back(mk(KIND_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    rows.push_back(mk(KIND_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 32'd1,
                      32'd1, 1'b0));
    rows.push_back(mk(KIND_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
    foreach (rows[i]) send_fraction_pair(rows[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i > N_RANDOM - 200) quiet_phase = 1'b1;
      r = mk(kind_t'($urandom_range(0, 3)), random_operand(), random_operand(),
             random_operand(), random_operand());
      send_fraction_pair(r);
    end
    s_axis_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver: random stalls, one long hold-off early in the random part.
  initial begin
    int accepted;
    m_axis_tready = 1'b0;
    hold_long = 1'b0;
    accepted = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) accepted++;
      if (accepted == 40 && !hold_long) begin
        hold_long = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk);
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    fraction_result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_fractions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
      end else begin
        e = pending_fractions.pop_front();
        if (m_axis_tdata[31:0] !== e.num || m_axis_tdata[63:32] !== e.den ||
            m_axis_tuser !== e.dz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d dz=%b, got %0d/%0d dz=%b",
                     $signed(e.num), $signed(e.den), e.dz,
                     $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]),
                     m_axis_tuser);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // End of run.
  initial begin
    mismatches  = 0;
    idle_cycles = 0;
    fork
      begin
        wait (sending_done && pending_fractions.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_fractions.size() == 0) begin
          $display("CHECK OK");
        end else begin
          $display("CHECK FAILED");
        end
      end
      begin
        wait (idle_cycles >= WATCH_MAX);
        $display("timeout with %0d results outstanding", pending_fractions.size());
        $display("CHECK FAILED");
      end
    join_any
    $finish;
  end

endmodule
`default_nettype wire
